/* rtl/core/cht_pkg.sv */
package cht_pkg;

  localparam int SLOT_W    = 4;
  localparam int SLOTS     = 1 << SLOT_W;
  localparam int STEP_W    = SLOT_W + 1;
  localparam int KEY_BITS  = 16;
  localparam int PAYLOAD_W = 32;

  localparam logic [STEP_W-1:0] SLOTS_N   = STEP_W'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = '1;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_FOUND     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_CLEARED   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HOME,
    ST_SCAN,
    ST_WALK,
    ST_LOOK
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [SLOT_W-1:0] rd_addr;
  } ram_req_t;

  typedef struct packed {
    status_e              status;
    logic [SLOT_W-1:0]    slot;
    logic [STEP_W-1:0]    steps;
    logic [PAYLOAD_W-1:0] payload;
  } result_t;

endpackage

/* rtl/core/cht_ram.sv */
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

/* rtl/core/cht_seq.sv */
module cht_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cht_pkg::kind_e                  in_kind_i,
  input  logic [cht_pkg::KEY_BITS-1:0]    in_key_i,
  input  logic [cht_pkg::PAYLOAD_W-1:0]   in_payload_i,
  output logic                            res_valid_o,
  output cht_pkg::result_t                res_o,
  input  logic                            res_ready_i,
  output cht_pkg::ram_req_t               ram_req_o,
  input  cht_pkg::entry_t                 ram_rd_i
);

  localparam int SW = cht_pkg::SLOT_W;
  localparam int NS = cht_pkg::SLOTS;

  cht_pkg::state_e                  state_q, state_d;
  logic [SW-1:0]                    ptr_q, ptr_d;
  logic [SW-1:0]                    dst_q, dst_d;
  logic [cht_pkg::STEP_W-1:0]       n_q, n_d, n_inc;
  logic                             ins_q, ins_d;
  logic [cht_pkg::KEY_BITS-1:0]     key_q, key_d;
  logic [cht_pkg::PAYLOAD_W-1:0]    pay_q, pay_d;
  logic [NS-1:0]                    used_q, used_d;
  logic [NS-1:0]                    lv_q, lv_d;
  logic [SW-1:0]                    link_q [NS];
  logic [SW-1:0]                    link_d [NS];

  logic [SW-1:0] home_in, home_q, free_idx, start_slot;
  logic          free_any, home_ok, key_hit, do_start, no_chain;

  assign home_in = in_key_i[SW-1:0];
  assign home_q  = key_q[SW-1:0];
  assign n_inc   = n_q + 1'b1;

  // shared compare on the probed entry
  assign home_ok = (ram_rd_i.key[SW-1:0] == home_q);
  assign key_hit = (ram_rd_i.key == key_q);

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    dst_d       = dst_q;
    n_d         = n_q;
    ins_d       = ins_q;
    key_d       = key_q;
    pay_d       = pay_q;
    used_d      = used_q;
    lv_d        = lv_q;
    link_d      = link_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    ram_req_o.wr_en           = 1'b0;
    ram_req_o.wr_addr         = dst_q;
    ram_req_o.wr_data.key     = key_q;
    ram_req_o.wr_data.payload = pay_q;
    ram_req_o.rd_addr         = ptr_q;
    do_start   = 1'b0;
    no_chain   = 1'b0;
    start_slot = ptr_q;

    unique case (state_q)
      cht_pkg::ST_IDLE: begin
        in_ready_o = res_ready_i;
        ram_req_o.rd_addr = home_in;
        if (in_valid_i && res_ready_i) begin
          key_d = in_key_i;
          pay_d = in_payload_i;
          ptr_d = home_in;
          unique case (in_kind_i)
            cht_pkg::KIND_INSERT: begin
              ins_d = 1'b1;
              if (!used_q[home_in]) begin
                ram_req_o.wr_en           = 1'b1;
                ram_req_o.wr_addr         = home_in;
                ram_req_o.wr_data.key     = in_key_i;
                ram_req_o.wr_data.payload = in_payload_i;
                used_d[home_in] = 1'b1;
                lv_d[home_in]   = 1'b0;
                res_valid_o     = 1'b1;
                res_o.status    = cht_pkg::STAT_INSERTED;
                res_o.slot      = home_in;
              end else if (!free_any) begin
                res_valid_o  = 1'b1;
                res_o.status = cht_pkg::STAT_FULL;
              end else begin
                dst_d   = free_idx;
                state_d = cht_pkg::ST_HOME;
              end
            end
            cht_pkg::KIND_LOOKUP: begin
              ins_d   = 1'b0;
              state_d = cht_pkg::ST_HOME;
            end
            cht_pkg::KIND_CLEAR: begin
              used_d       = '0;
              lv_d         = '0;
              res_valid_o  = 1'b1;
              res_o.status = cht_pkg::STAT_CLEARED;
            end
            default: begin
            end
          endcase
        end
      end
      cht_pkg::ST_HOME: begin
        if (used_q[home_q] && home_ok) begin
          do_start   = 1'b1;
          start_slot = home_q;
        end else begin
          ptr_d             = '0;
          ram_req_o.rd_addr = '0;
          state_d           = cht_pkg::ST_SCAN;
        end
      end
      cht_pkg::ST_SCAN: begin
        if (used_q[ptr_q] && home_ok) begin
          do_start   = 1'b1;
          start_slot = ptr_q;
        end else if (ptr_q == cht_pkg::LAST_SLOT) begin
          no_chain = 1'b1;
        end else begin
          ptr_d             = ptr_q + 1'b1;
          ram_req_o.rd_addr = ptr_q + 1'b1;
        end
      end
      cht_pkg::ST_WALK: begin
        if (n_q < cht_pkg::SLOTS_N && lv_q[ptr_q]) begin
          ptr_d = link_q[ptr_q];
          n_d   = n_inc;
        end else begin
          lv_d[ptr_q]   = 1'b1;
          link_d[ptr_q] = dst_q;
          no_chain      = 1'b1;
        end
      end
      cht_pkg::ST_LOOK: begin
        if (used_q[ptr_q] && key_hit) begin
          res_valid_o   = 1'b1;
          res_o.status  = cht_pkg::STAT_FOUND;
          res_o.slot    = ptr_q;
          res_o.steps   = n_inc;
          res_o.payload = ram_rd_i.payload;
          state_d       = cht_pkg::ST_IDLE;
        end else if (!lv_q[ptr_q] || n_inc == cht_pkg::SLOTS_N) begin
          res_valid_o  = 1'b1;
          res_o.status = cht_pkg::STAT_NOT_FOUND;
          res_o.steps  = n_inc;
          state_d      = cht_pkg::ST_IDLE;
        end else begin
          ptr_d             = link_q[ptr_q];
          ram_req_o.rd_addr = link_q[ptr_q];
          n_d               = n_inc;
        end
      end
      default: begin
        state_d = cht_pkg::ST_IDLE;
      end
    endcase

    if (do_start) begin
      ptr_d             = start_slot;
      ram_req_o.rd_addr = start_slot;
      if (ins_q) begin
        n_d     = cht_pkg::STEP_W'(1);
        state_d = cht_pkg::ST_WALK;
      end else begin
        n_d     = '0;
        state_d = cht_pkg::ST_LOOK;
      end
    end

    // end of insert (linked or unlinked), or lookup with no chain
    if (no_chain) begin
      state_d     = cht_pkg::ST_IDLE;
      res_valid_o = 1'b1;
      if (ins_q) begin
        ram_req_o.wr_en = 1'b1;
        used_d[dst_q]   = 1'b1;
        lv_d[dst_q]     = 1'b0;
        res_o.status    = cht_pkg::STAT_INSERTED;
        res_o.slot      = dst_q;
      end else begin
        res_o.status = cht_pkg::STAT_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cht_pkg::ST_IDLE;
      ptr_q   <= '0;
      dst_q   <= '0;
      n_q     <= '0;
      ins_q   <= 1'b0;
      used_q  <= '0;
      lv_q    <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      dst_q   <= dst_d;
      n_q     <= n_d;
      ins_q   <= ins_d;
      used_q  <= used_d;
      lv_q    <= lv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    pay_q  <= pay_d;
    link_q <= link_d;
  end

`ifndef SYNTHESIS
  a_walk_dst_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cht_pkg::ST_WALK |-> !used_q[dst_q])
    else $error("insert target taken during chain walk");

  a_look_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cht_pkg::ST_LOOK |-> used_q[ptr_q])
    else $error("lookup visits an empty slot");

  a_look_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cht_pkg::ST_LOOK |-> n_q < cht_pkg::SLOTS_N)
    else $error("lookup step count out of range");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cht_pkg::ST_IDLE && in_valid_i && res_ready_i &&
     in_kind_i == cht_pkg::KIND_CLEAR) |=> (used_q == '0 && lv_q == '0))
    else $error("clear left slots in use");
`endif

endmodule

/* rtl/core/coalesced_hash_table.sv */
// Coalesced-chaining hash table, 16 slots, 16-bit keys, 32-bit payloads; home slot is the
// low 4 key bits. Clear, an insert whose home slot is free and an insert into a full table
// finish in the transfer cycle. Any other insert or lookup takes the transfer cycle, then
// probes the home slot, then scans up to 16 slots for the chain start when the home slot
// does not start the chain, then walks the chain entry by entry (up to 16 entries). The
// key/payload RAM has one read port and is probed one slot per cycle. The result is
// registered and appears on the output in the cycle after it is formed. The input is not
// ready while an item is in progress, and a new item is taken while the output register
// is empty or being drained. The table resets empty; kind 3 transfers produce no result.
module coalesced_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // key[15:0], payload[47:16]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // slot[3:0], steps[8:4], found_payload[40:9], zero
  output logic [2:0]  m_axis_tuser   // status[2:0]
);

  cht_pkg::ram_req_t ram_req;
  cht_pkg::entry_t   ram_rd;
  cht_pkg::result_t  res, res_q;
  logic              res_valid, res_ready;
  logic              out_valid_q, out_valid_d;

  assign res_ready = !out_valid_q || m_axis_tready;

  cht_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (cht_pkg::kind_e'(s_axis_tuser)),
    .in_key_i     (s_axis_tdata[15:0]),
    .in_payload_i (s_axis_tdata[47:16]),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .ram_req_o    (ram_req),
    .ram_rd_i     (ram_rd)
  );

  cht_ram #(
    .WIDTH ($bits(cht_pkg::entry_t)),
    .DEPTH (cht_pkg::SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.wr_addr),
    .wr_data_i (ram_req.wr_data),
    .rd_addr_i (ram_req.rd_addr),
    .rd_data_o (ram_rd)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {7'b0, res_q.payload, res_q.steps, res_q.slot};

endmodule

/* tb/tb_coalesced_hash_table.sv */
module tb_coalesced_hash_table;
  import cht_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int QUIET_FROM  = 3000;
  localparam int QUIET_TO    = 9000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct {
    logic [1:0]           kind;
    logic [KEY_BITS-1:0]  key;
    logic [PAYLOAD_W-1:0] payload;
  } op_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;  // key[15:0], payload[47:16]
  logic [1:0]  s_axis_tuser  = '0;  // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // slot[3:0], steps[8:4], found_payload[40:9], zero
  logic [2:0]  m_axis_tuser;        // status[2:0]

  op_t     ops_pending[$];
  result_t results_due[$];
  int      ops_total;
  int      ops_taken = 0;
  int      errors    = 0;
  int      cyc       = 0;

  // table shadow
  bit                   used_q    [SLOTS];
  logic [KEY_BITS-1:0]  key_q     [SLOTS];
  bit                   link_ok_q [SLOTS];
  logic [SLOT_W-1:0]    link_q    [SLOTS];
  logic [PAYLOAD_W-1:0] pay_q     [SLOTS];

  coalesced_hash_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("tb_coalesced_hash_table NOT OK");
      $finish;
    end
  end

  function automatic bit pause_now();
    return !(cyc >= QUIET_FROM && cyc < QUIET_TO) && $urandom_range(99) < 30;
  endfunction

  function automatic int chain_head(logic [SLOT_W-1:0] home);
    if (used_q[home] && key_q[home][SLOT_W-1:0] == home) return int'(home);
    for (int i = 0; i < SLOTS; i++)
      if (used_q[i] && key_q[i][SLOT_W-1:0] == home) return i;
    return -1;
  endfunction

  task automatic table_apply(input logic [1:0] kind, input logic [KEY_BITS-1:0] key,
                             input logic [PAYLOAD_W-1:0] pay, output bit emits,
                             output result_t res);
    logic [SLOT_W-1:0] home;
    int cur, dst, n;
    bit done;
    home  = key[SLOT_W-1:0];
    emits = 1'b1;
    res   = '0;
    case (kind)
      KIND_INSERT: begin
        dst = -1;
        if (!used_q[home]) begin
          dst = int'(home);
        end else begin
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!used_q[i]) dst = i;
          if (dst >= 0) begin
            cur = chain_head(home);
            if (cur >= 0) begin
              n = 1;
              while (n < SLOTS && link_ok_q[cur]) begin
                cur = int'(link_q[cur]);
                n++;
              end
              link_ok_q[cur] = 1'b1;
              link_q[cur]    = dst[SLOT_W-1:0];
            end
          end
        end
        if (dst < 0) begin
          res.status = STAT_FULL;
        end else begin
          used_q[dst]    = 1'b1;
          key_q[dst]     = key;
          pay_q[dst]     = pay;
          link_ok_q[dst] = 1'b0;
          link_q[dst]    = '0;
          res.status     = STAT_INSERTED;
          res.slot       = dst[SLOT_W-1:0];
        end
      end
      KIND_LOOKUP: begin
        res.status = STAT_NOT_FOUND;
        cur  = chain_head(home);
        n    = 0;
        done = 1'b0;
        if (cur >= 0) begin
          while (!done && n < SLOTS) begin
            n++;
            if (used_q[cur] && key_q[cur] == key) begin
              res.status  = STAT_FOUND;
              res.slot    = cur[SLOT_W-1:0];
              res.payload = pay_q[cur];
              done = 1'b1;
            end else if (!link_ok_q[cur]) begin
              done = 1'b1;
            end else begin
              cur = int'(link_q[cur]);
            end
          end
        end
        res.steps = n[STEP_W-1:0];
      end
      KIND_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          used_q[i]    = 1'b0;
          link_ok_q[i] = 1'b0;
        end
        res.status = STAT_CLEARED;
      end
      default: emits = 1'b0;
    endcase
  endtask

  task automatic flag_error(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR t=%0t %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic add_op(logic [1:0] kind, logic [KEY_BITS-1:0] key,
                        logic [PAYLOAD_W-1:0] payload);
    op_t op;
    op.kind    = kind;
    op.key     = key;
    op.payload = payload;
    ops_pending.push_back(op);
  endtask

  // driver
  always @(posedge clk_i) begin : drive_in
    op_t op;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (ops_pending.size() != 0 && !pause_now()) begin
        op = ops_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op.kind;
        s_axis_tdata  <= {op.payload, op.key};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && !pause_now();
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i) begin : watch
    result_t want;
    bit emits;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      table_apply(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16], emits, want);
      if (emits) results_due.push_back(want);
      ops_taken <= ops_taken + 1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        flag_error("result with none pending, tdata", m_axis_tdata[31:0], '0);
      end else begin
        want = results_due.pop_front();
        if (m_axis_tuser != want.status)
          flag_error("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata[3:0] != want.slot)
          flag_error("slot", 32'(m_axis_tdata[3:0]), 32'(want.slot));
        if (m_axis_tdata[8:4] != want.steps)
          flag_error("steps", 32'(m_axis_tdata[8:4]), 32'(want.steps));
        if (m_axis_tdata[40:9] != want.payload)
          flag_error("found_payload", m_axis_tdata[40:9], want.payload);
        if (m_axis_tdata[47:41] != '0)
          flag_error("pad bits", 32'(m_axis_tdata[47:41]), '0);
      end
    end
  end

  initial begin
    logic [KEY_BITS-1:0] keys[$];
    logic [SLOT_W-1:0]   homes[4];
    logic [KEY_BITS-1:0] k;
    int npool, len, r;

    // chains, duplicates, chain starting off its home slot, misses, full, clear
    add_op(KIND_INSERT, 16'h0000, 32'h0000_0000);
    add_op(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    add_op(KIND_INSERT, 16'h0010, 32'h1234_5678);
    add_op(KIND_INSERT, 16'h0001, 32'h8765_4321);
    add_op(KIND_INSERT, 16'h0011, 32'hDEAD_BEEF);
    add_op(KIND_INSERT, 16'h0000, 32'hA5A5_A5A5);
    add_op(KIND_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
    add_op(KIND_LOOKUP, 16'h0011, 32'h0);
    add_op(KIND_LOOKUP, 16'h0030, 32'h0);
    add_op(KIND_LOOKUP, 16'h0005, 32'h0);
    add_op(KIND_LOOKUP, 16'hFFFF, 32'h0);
    add_op(KIND_UNUSED, 16'h0000, 32'h5A5A_5A5A);
    add_op(KIND_LOOKUP, 16'h0010, 32'h0);
    for (int i = 1; i <= 10; i++)
      add_op(KIND_INSERT, KEY_BITS'(i << 8), $urandom);
    add_op(KIND_LOOKUP, 16'h0A00, 32'h0);
    add_op(KIND_INSERT, 16'h1234, 32'hCAFE_F00D);
    add_op(KIND_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    add_op(KIND_LOOKUP, 16'h0000, 32'h0);

    // episodes of keys drawn from a few home values, so chains overlap
    while (ops_pending.size() < 1225) begin
      if ($urandom_range(99) < 75) begin
        add_op(KIND_CLEAR, KEY_BITS'($urandom), $urandom);
        keys.delete();
      end
      npool = $urandom_range(1, 4);
      foreach (homes[i]) homes[i] = SLOT_W'($urandom);
      len = $urandom_range(8, 40);
      for (int j = 0; j < len; j++) begin
        r = $urandom_range(99);
        k = {12'($urandom), homes[$urandom_range(npool - 1)]};
        if (r < 50) begin
          if (r < 8 && keys.size() != 0) k = keys[$urandom_range(keys.size() - 1)];
          else if (r >= 46) k = KEY_BITS'($urandom);
          keys.push_back(k);
          add_op(KIND_INSERT, k, $urandom);
        end else if (r < 92) begin
          if (r < 78 && keys.size() != 0) k = keys[$urandom_range(keys.size() - 1)];
          else if (r >= 88) k = KEY_BITS'($urandom);
          add_op(KIND_LOOKUP, k, $urandom);
        end else if (r < 96) begin
          add_op(KIND_UNUSED, KEY_BITS'($urandom), $urandom);
        end else begin
          add_op(KIND_CLEAR, KEY_BITS'($urandom), $urandom);
          keys.delete();
        end
      end
    end
    ops_total = ops_pending.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (ops_taken < ops_total) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_coalesced_hash_table OK");
    end else begin
      $display("tb_coalesced_hash_table NOT OK");
    end
    $finish;
  end

endmodule
